@@ hdl/uart_tx_rx_ring_buffer_assert.svh @@
// Assertion macros for the UART ring buffer block.
// Used by the top level; expects a clk and rst in scope.
`ifndef UART_TX_RX_RING_BUFFER_ASSERT_SVH
`define UART_TX_RX_RING_BUFFER_ASSERT_SVH

// same-cycle implication
`define UTRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/utrb_pkg.sv @@
// Shared types and constants for the UART ring buffer block.
// No dependencies.
package utrb_pkg;

  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_AW    = $clog2(RX_DEPTH);

  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_STATUS = 2'd2,
    OP_IDLE   = 2'd3
  } op_t;

  // memory access for one ring
  typedef struct packed {
    logic             we;
    logic [TX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [TX_AW-1:0] raddr;
  } tx_req_t;

  typedef struct packed {
    logic             we;
    logic [RX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [RX_AW-1:0] raddr;
  } rx_req_t;

  // per-beat result flags, bytes come later from the memories
  typedef struct packed {
    logic       accepted;
    logic       pop;
    logic       send;
    logic       drop;
    logic       tie;
    logic [2:0] last_err;
    logic       eclr;
  } res_t;

endpackage

@@ hdl/utrb_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module utrb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/utrb_ctrl.sv @@
// Ring pointers, interrupt enable and error latch for the UART ring buffer.
// Depends on utrb_pkg.
module utrb_ctrl
  import utrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       beat,
  input  op_t        op,
  input  logic [7:0] host_byte,
  input  logic       tx_empty,
  input  logic       rx_full,
  input  logic [2:0] err_bits,
  input  logic [7:0] rx_byte,
  output tx_req_t    tx_req,
  output rx_req_t    rx_req,
  output res_t       res
);

  logic [TX_AW-1:0] tx_head, tx_tail, tx_head_inc, tx_tail_inc;
  logic [RX_AW-1:0] rx_head, rx_tail, rx_head_inc, rx_tail_inc;
  logic             tie;
  logic [2:0]       err_latch;

  logic push_ok, pop_ok, send, tie_clr, store, drop, eclr, is_status;

  always_comb begin
    tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + TX_AW'(1);
    tx_tail_inc = (tx_tail == TX_LAST) ? '0 : tx_tail + TX_AW'(1);
    rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + RX_AW'(1);
    rx_tail_inc = (rx_tail == RX_LAST) ? '0 : rx_tail + RX_AW'(1);

    is_status = (op == OP_STATUS);
    push_ok   = (op == OP_PUSH) && (tx_head_inc != tx_tail);
    pop_ok    = (op == OP_POP) && (rx_tail != rx_head);
    send      = is_status && tx_empty && (tx_tail != tx_head);
    tie_clr   = is_status && tx_empty && (tx_tail == tx_head);
    store     = is_status && rx_full && (rx_head_inc != rx_tail);
    drop      = is_status && rx_full && (rx_head_inc == rx_tail);
    eclr      = is_status && (err_bits != 3'd0);

    tx_req.we    = beat && push_ok;
    tx_req.waddr = tx_head;
    tx_req.wdata = host_byte;
    tx_req.re    = beat && send;
    tx_req.raddr = tx_tail;

    rx_req.we    = beat && store;
    rx_req.waddr = rx_head;
    rx_req.wdata = rx_byte;
    rx_req.re    = beat && pop_ok;
    rx_req.raddr = rx_tail;

    res.accepted = push_ok || pop_ok;
    res.pop      = pop_ok;
    res.send     = send;
    res.drop     = drop;
    res.tie      = push_ok ? 1'b1 : (tie_clr ? 1'b0 : tie);
    res.last_err = eclr ? err_bits : err_latch;
    res.eclr     = eclr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head   <= '0;
      tx_tail   <= '0;
      rx_head   <= '0;
      rx_tail   <= '0;
      tie       <= 1'b0;
      err_latch <= 3'd0;
    end else if (beat) begin
      if (push_ok) tx_head <= tx_head_inc;
      if (send)    tx_tail <= tx_tail_inc;
      if (store)   rx_head <= rx_head_inc;
      if (pop_ok)  rx_tail <= rx_tail_inc;
      tie       <= res.tie;
      err_latch <= res.last_err;
    end
  end

endmodule

@@ hdl/uart_tx_rx_ring_buffer.sv @@
// UART transmit/receive ring buffer, top level.
// An input beat goes through stage 1 (memory read) and the output register.
// One item per cycle unless the sink stalls; at most one access per ring memory.
// Pointers are updated at input accept, so a following item sees them at once.
// Reset (rst, sync, active high) clears pointers, interrupt enable, error latch
// and the pipeline valids; ring memories are not cleared (read only once written).
module uart_tx_rx_ring_buffer
  import utrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input beat
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] host_byte, [8] tx_empty, [9] rx_full, [12:10] err_bits,
  // [20:13] rx_byte, [23:21] zero
  input  logic [23:0] s_tdata,
  // [1:0] op
  input  logic [1:0]  s_tuser,
  // result beat
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [8:1] read_byte, [9] send_valid, [17:10] send_byte,
  // [18] rx_dropped, [19] tx_irq_enable, [22:20] last_error, [23] err_clear
  output logic [23:0] m_tdata
);

  `include "uart_tx_rx_ring_buffer_assert.svh"

  logic    s_beat;
  logic    s1_valid, s1_adv;
  res_t    res, s1_res;
  tx_req_t tx_req;
  rx_req_t rx_req;
  logic [7:0] tx_rdata, rx_rdata;

  // stage 1 holds the flags while the memory read lands; rdata holds
  // under stall because the read port is only enabled on an input beat
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign s_beat   = s_tvalid && s_tready;

  utrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .beat      (s_beat),
    .op        (op_t'(s_tuser)),
    .host_byte (s_tdata[7:0]),
    .tx_empty  (s_tdata[8]),
    .rx_full   (s_tdata[9]),
    .err_bits  (s_tdata[12:10]),
    .rx_byte   (s_tdata[20:13]),
    .tx_req    (tx_req),
    .rx_req    (rx_req),
    .res       (res)
  );

  utrb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_req.we),
    .waddr (tx_req.waddr),
    .wdata (tx_req.wdata),
    .re    (tx_req.re),
    .raddr (tx_req.raddr),
    .rdata (tx_rdata)
  );

  utrb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_req.we),
    .waddr (rx_req.waddr),
    .wdata (rx_req.wdata),
    .re    (rx_req.re),
    .raddr (rx_req.raddr),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_beat) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      s1_res <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {s1_res.eclr, s1_res.last_err, s1_res.tie, s1_res.drop,
                  s1_res.send ? tx_rdata : 8'd0, s1_res.send,
                  s1_res.pop ? rx_rdata : 8'd0, s1_res.accepted};
    end
  end

  // popped byte only on a granted pop
  `UTRB_ASSERT_NOW(a_pop_byte, m_tvalid && |m_tdata[8:1], m_tdata[0],
                   "read_byte without accept")
  // sent byte only with send_valid
  `UTRB_ASSERT_NOW(a_send_byte, m_tvalid && |m_tdata[17:10], m_tdata[9],
                   "send_byte without send_valid")
  // stalled stage 1 keeps its read data
  `UTRB_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv,
                    s1_valid && $stable(tx_rdata) && $stable(rx_rdata),
                    "stage 1 lost data under stall")
  // an input beat always lands in stage 1
  `UTRB_ASSERT_NEXT(a_s1_fill, s_beat, s1_valid, "input beat not captured")

endmodule

@@ dv/tb.sv @@
// Testbench for uart_tx_rx_ring_buffer: queued stream beats, a per-beat ring model,
// result beats checked in order. Depends on utrb_pkg and the top-level RTL only.
module tb;
  import utrb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;    // wait after the queues empty, with slack
  localparam int BURSTS       = 10;
  localparam int BURST_LEN    = 40;
  localparam int HOLD_AT_BEAT = 150;   // sink back-pressure starts here
  localparam int HOLD_CYCLES  = 60;

  // one host/serial item as it goes onto the input bus, plus the idle gap after it
  typedef struct packed {
    op_t        op;
    logic [7:0] host_byte;
    logic       tx_empty;
    logic       rx_full;
    logic [2:0] err_bits;
    logic [7:0] rx_byte;
    logic [2:0] gap;
  } uart_beat_t;

  // same bit layout as m_tdata, so the bus word casts straight in
  typedef struct packed {
    logic       err_clear;
    logic [2:0] last_error;
    logic       tx_irq_enable;
    logic       rx_dropped;
    logic [7:0] send_byte;
    logic       send_valid;
    logic [7:0] read_byte;
    logic       accepted;
  } ring_result_t;

  typedef enum logic [1:0] {FILL_RINGS, DRAIN_RINGS, MIXED} burst_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  uart_tx_rx_ring_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ring model: both rings, their pointers, irq enable and error latch.
  // Each ring keeps one slot free, so 15 bytes fit at depth 16.
  // ---------------------------------------------------------------------------
  logic [7:0]       tx_ring [TX_DEPTH];
  logic [7:0]       rx_ring [RX_DEPTH];
  logic [TX_AW-1:0] tx_wr = '0;
  logic [TX_AW-1:0] tx_rd = '0;
  logic [RX_AW-1:0] rx_wr = '0;
  logic [RX_AW-1:0] rx_rd = '0;
  logic             irq_en = 1'b0;
  logic [2:0]       err_hold = '0;

  function automatic ring_result_t predict_ring_beat(uart_beat_t b);
    ring_result_t     r;
    logic [TX_AW-1:0] tx_nxt;
    logic [RX_AW-1:0] rx_nxt;
    r = '0;
    tx_nxt = (tx_wr == TX_LAST) ? '0 : TX_AW'(tx_wr + 1'b1);
    rx_nxt = (rx_wr == RX_LAST) ? '0 : RX_AW'(rx_wr + 1'b1);
    case (b.op)
      OP_PUSH: begin
        // full ring refuses and leaves irq enable alone
        if (tx_nxt != tx_rd) begin
          tx_ring[tx_wr] = b.host_byte;
          tx_wr = tx_nxt;
          irq_en = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_POP: begin
        if (rx_rd != rx_wr) begin
          r.accepted = 1'b1;
          r.read_byte = rx_ring[rx_rd];
          rx_rd = (rx_rd == RX_LAST) ? '0 : RX_AW'(rx_rd + 1'b1);
        end
      end
      OP_STATUS: begin
        if (b.tx_empty) begin
          if (tx_rd != tx_wr) begin
            r.send_valid = 1'b1;
            r.send_byte = tx_ring[tx_rd];
            tx_rd = (tx_rd == TX_LAST) ? '0 : TX_AW'(tx_rd + 1'b1);
          end else begin
            irq_en = 1'b0;   // nothing left to send
          end
        end
        if (b.rx_full) begin
          if (rx_nxt != rx_rd) begin
            rx_ring[rx_wr] = b.rx_byte;
            rx_wr = rx_nxt;
          end else begin
            r.rx_dropped = 1'b1;
          end
        end
        if (b.err_bits != 3'd0) begin
          err_hold = b.err_bits;
          r.err_clear = 1'b1;
        end
      end
      default: ;             // unused code: no change
    endcase
    r.tx_irq_enable = irq_en;
    r.last_error = err_hold;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store and builders
  // ---------------------------------------------------------------------------
  uart_beat_t   host_beats [$];
  ring_result_t results_due [$];

  function automatic uart_beat_t random_beat(burst_kind_t kind, bit calm);
    uart_beat_t  b;
    int unsigned roll;
    b.op        = op_t'($urandom_range(0, 3));
    b.host_byte = 8'($urandom);
    b.tx_empty  = 1'($urandom_range(0, 1));
    b.rx_full   = 1'($urandom_range(0, 1));
    b.err_bits  = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    b.rx_byte   = 8'($urandom);
    b.gap       = calm ? 3'd0 : 3'($urandom_range(0, 5));
    roll = $urandom_range(0, 99);
    case (kind)
      FILL_RINGS: begin
        // mostly pushes and received bytes with the transmitter busy
        if (roll < 45) begin
          b.op = OP_PUSH;
        end else if (roll < 88) begin
          b.op = OP_STATUS;
          b.rx_full = 1'b1;
          b.tx_empty = ($urandom_range(0, 3) == 0);
        end else if (roll < 96) begin
          b.op = OP_POP;
        end else begin
          b.op = OP_IDLE;
        end
      end
      DRAIN_RINGS: begin
        if (roll < 40) begin
          b.op = OP_POP;
        end else if (roll < 88) begin
          b.op = OP_STATUS;
          b.tx_empty = 1'b1;
          b.rx_full = ($urandom_range(0, 3) == 0);
        end else if (roll < 96) begin
          b.op = OP_PUSH;
        end else begin
          b.op = OP_IDLE;
        end
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic queue_beat(op_t op, logic [7:0] hb, logic te, logic rf,
                            logic [2:0] eb, logic [7:0] rb);
    uart_beat_t b;
    b.op = op;
    b.host_byte = hb;
    b.tx_empty = te;
    b.rx_full = rf;
    b.err_bits = eb;
    b.rx_byte = rb;
    b.gap = 3'($urandom_range(0, 5));
    host_beats.push_back(b);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued beats, predicts on each accepted one
  // ---------------------------------------------------------------------------
  uart_beat_t  beat_on_bus;
  logic [2:0]  idle_left = '0;
  int unsigned beats_in = 0;

  always @(posedge clk) begin
    uart_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      idle_left <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(predict_ring_beat(beat_on_bus));
        beats_in <= beats_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (idle_left != 3'd0) begin
          idle_left <= idle_left - 3'd1;
          s_tvalid <= 1'b0;
        end else if (host_beats.size() != 0) begin
          nxt = host_beats.pop_front();
          beat_on_bus <= nxt;
          s_tdata <= {3'b000, nxt.rx_byte, nxt.err_bits, nxt.rx_full, nxt.tx_empty,
                      nxt.host_byte};
          s_tuser <= nxt.op;
          s_tvalid <= 1'b1;
          idle_left <= nxt.gap;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long sink hold-off, once, so the pipeline backs up into s_tready
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random sink stalls, checks every result beat in order
  // ---------------------------------------------------------------------------
  int unsigned sink_wait = 0;
  int unsigned calm_beats = 0;
  bit          sink_calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  function automatic string fmt_result(ring_result_t r);
    return $sformatf("acc=%0b rd=%02h snd=%0b/%02h drop=%0b ie=%0b err=%0d clr=%0b",
                     r.accepted, r.read_byte, r.send_valid, r.send_byte, r.rx_dropped,
                     r.tx_irq_enable, r.last_error, r.err_clear);
  endfunction

  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    int unsigned  wait_n;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else begin
      wait_n = sink_wait;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen <= results_seen + 1;
        if (results_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat %0d: %s", results_seen, fmt_result(got));
          mismatches <= mismatches + 1;
        end else begin
          want = results_due.pop_front();
          if (got.accepted !== want.accepted || got.read_byte !== want.read_byte ||
              got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
              got.rx_dropped !== want.rx_dropped ||
              got.tx_irq_enable !== want.tx_irq_enable ||
              got.last_error !== want.last_error || got.err_clear !== want.err_clear) begin
            if (mismatches < 10)
              $display("mismatch at result %0d\n  exp %s\n  got %s", results_seen,
                       fmt_result(want), fmt_result(got));
            mismatches <= mismatches + 1;
          end
        end
        // stall pattern comes in stretches, some with no stalls at all
        if (calm_beats == 0) begin
          sink_calm <= ($urandom_range(0, 3) == 0);
          calm_beats <= $urandom_range(10, 40);
        end else begin
          calm_beats <= calm_beats - 1;
        end
        wait_n = sink_calm ? 0 : $urandom_range(0, 5);
      end else if (wait_n != 0) begin
        wait_n = wait_n - 1;
      end
      sink_wait <= wait_n;
      m_tready <= (wait_n == 0) && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed beats, random bursts, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    burst_kind_t kind;
    bit          calm;

    // pop from empty ring, then transmitter empty with nothing queued
    queue_beat(OP_POP, 8'hFF, 1'b1, 1'b1, 3'd7, 8'hFF);
    queue_beat(OP_STATUS, 8'hFF, 1'b1, 1'b0, 3'd0, 8'h00);
    // extreme bytes through the transmit ring
    queue_beat(OP_PUSH, 8'h00, 1'b1, 1'b1, 3'd7, 8'hFF);
    queue_beat(OP_PUSH, 8'hFF, 1'b0, 1'b0, 3'd0, 8'h00);
    queue_beat(OP_PUSH, 8'hA5, 1'b1, 1'b1, 3'd7, 8'hFF);
    // send + store + latch all errors in one event
    queue_beat(OP_STATUS, 8'h00, 1'b1, 1'b1, 3'd7, 8'hFF);
    // no error bits: latch kept, no clear
    queue_beat(OP_STATUS, 8'hFF, 1'b1, 1'b1, 3'd0, 8'h00);
    queue_beat(OP_STATUS, 8'h00, 1'b1, 1'b0, 3'd1, 8'hFF);
    // transmit ring already empty: nothing sent, irq enable cleared
    queue_beat(OP_STATUS, 8'h00, 1'b1, 1'b1, 3'd4, 8'h5A);
    queue_beat(OP_STATUS, 8'h00, 1'b1, 1'b0, 3'd2, 8'h00);
    queue_beat(OP_POP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00);
    queue_beat(OP_POP, 8'hFF, 1'b1, 1'b1, 3'd7, 8'hFF);
    queue_beat(OP_POP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00);
    queue_beat(OP_POP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00);
    // unused op code with every other field set
    queue_beat(OP_IDLE, 8'hFF, 1'b1, 1'b1, 3'd7, 8'hFF);
    queue_beat(OP_IDLE, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00);
    // status with nothing to do
    queue_beat(OP_STATUS, 8'hFF, 1'b0, 1'b0, 3'd0, 8'hFF);
    // push sets irq enable again, then store and pop a received byte
    queue_beat(OP_PUSH, 8'h3C, 1'b0, 1'b0, 3'd0, 8'h00);
    queue_beat(OP_STATUS, 8'h00, 1'b0, 1'b1, 3'd0, 8'hC3);
    queue_beat(OP_POP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00);

    // random bursts, each biased toward filling, draining or neither
    for (int i = 0; i < BURSTS; i++) begin
      kind = burst_kind_t'($urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < BURST_LEN; j++)
        host_beats.push_back(random_beat(kind, calm));
    end
    // finish with a burst biased toward draining both rings
    for (int j = 0; j < BURST_LEN; j++)
      host_beats.push_back(random_beat(DRAIN_RINGS, 1'b0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (host_beats.size() != 0 || s_tvalid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (results_due.size() != 0)
      $display("%0d results never arrived", results_due.size());
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
